@@ src/mfoe_pkg.sv @@
`default_nettype none

package mfoe_pkg;

  // ITCH message type bytes (ASCII).
  localparam logic [7:0] MT_S = 8'h53;
  localparam logic [7:0] MT_R = 8'h52;
  localparam logic [7:0] MT_H = 8'h48;
  localparam logic [7:0] MT_Y = 8'h59;
  localparam logic [7:0] MT_L = 8'h4C;
  localparam logic [7:0] MT_V = 8'h56;
  localparam logic [7:0] MT_W = 8'h57;
  localparam logic [7:0] MT_K = 8'h4B;
  localparam logic [7:0] MT_J = 8'h4A;
  localparam logic [7:0] MT_LH = 8'h68;
  localparam logic [7:0] MT_A = 8'h41;
  localparam logic [7:0] MT_F = 8'h46;
  localparam logic [7:0] MT_E = 8'h45;
  localparam logic [7:0] MT_C = 8'h43;
  localparam logic [7:0] MT_X = 8'h58;
  localparam logic [7:0] MT_D = 8'h44;
  localparam logic [7:0] MT_U = 8'h55;
  localparam logic [7:0] MT_P = 8'h50;
  localparam logic [7:0] MT_Q = 8'h51;
  localparam logic [7:0] MT_B = 8'h42;
  localparam logic [7:0] MT_I = 8'h49;
  localparam logic [7:0] MT_N = 8'h4E;
  localparam logic [7:0] MT_O = 8'h4F;

  // Side byte that marks a buy order.
  localparam logic [7:0] SIDE_BUY = 8'h42;

  // Default depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Packed output record width; the type byte travels on tuser and the
  // remaining fields fill tdata, padded to whole bytes.
  localparam int REC_BITS   = 233;
  localparam int TYPE_BITS  = 8;
  localparam int TDATA_BITS = ((REC_BITS - TYPE_BITS + 7) / 8) * 8;

  // Which accumulator a body byte feeds.
  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_LOCATE,
    SEL_TIME,
    SEL_REF,
    SEL_NEW_REF,
    SEL_SHARES,
    SEL_PRICE,
    SEL_SIDE
  } field_sel_t;

  // One classified byte passed from the front to the back.
  typedef struct packed {
    logic       start;  // type byte: clear accumulators and latch type
    field_sel_t sel;    // destination field of a body byte
    logic       emit;   // last body byte of an order message
    logic [7:0] data;
  } mfoe_cmd_t;

  // One extracted order record.
  typedef struct packed {
    logic [31:0] order_count;
    logic        is_buy;
    logic [31:0] price;
    logic [31:0] shares;
    logic [31:0] new_order_ref;
    logic [31:0] order_ref;
    logic [47:0] timestamp;
    logic [15:0] stock_locate;
    logic [7:0]  message_type;
  } mfoe_rec_t;

endpackage

`default_nettype wire

@@ src/mfoe_front.sv @@
`default_nettype none

module mfoe_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_data,
  output logic                    cmd_valid,
  input  wire logic               cmd_ready,
  output mfoe_pkg::mfoe_cmd_t     cmd
);
  import mfoe_pkg::*;

  logic [5:0] bytes_left;
  logic [5:0] body_index;
  logic [7:0] current_type;
  logic       accept;
  logic       order_type;

  // Body length for each type byte; an unknown type eats one byte.
  function automatic logic [5:0] body_length(input logic [7:0] t);
    case (t)
      MT_S:    body_length = 6'd11;
      MT_R:    body_length = 6'd38;
      MT_H:    body_length = 6'd24;
      MT_Y:    body_length = 6'd19;
      MT_L:    body_length = 6'd25;
      MT_V:    body_length = 6'd34;
      MT_W:    body_length = 6'd11;
      MT_K:    body_length = 6'd27;
      MT_J:    body_length = 6'd34;
      MT_LH:   body_length = 6'd20;
      MT_A:    body_length = 6'd35;
      MT_F:    body_length = 6'd39;
      MT_E:    body_length = 6'd30;
      MT_C:    body_length = 6'd35;
      MT_X:    body_length = 6'd22;
      MT_D:    body_length = 6'd18;
      MT_U:    body_length = 6'd34;
      MT_P:    body_length = 6'd43;
      MT_Q:    body_length = 6'd39;
      MT_B:    body_length = 6'd18;
      MT_I:    body_length = 6'd49;
      MT_N:    body_length = 6'd19;
      MT_O:    body_length = 6'd47;
      default: body_length = 6'd1;
    endcase
  endfunction

  // Field routing by message type and body offset.
  function automatic field_sel_t route(input logic [7:0] t, input logic [5:0] i);
    field_sel_t s;
    s = SEL_NONE;
    if (i <= 6'd1) begin
      s = SEL_LOCATE;
    end else if (i inside {[6'd4:6'd9]}) begin
      s = SEL_TIME;
    end else if (i inside {[6'd10:6'd17]}) begin
      s = SEL_REF;
    end else if (t == MT_A || t == MT_F) begin
      if (i == 6'd18) begin
        s = SEL_SIDE;
      end else if (i inside {[6'd19:6'd22]}) begin
        s = SEL_SHARES;
      end else if (i inside {[6'd31:6'd34]}) begin
        s = SEL_PRICE;
      end
    end else if (t == MT_E || t == MT_C || t == MT_X) begin
      if (i inside {[6'd18:6'd21]}) begin
        s = SEL_SHARES;
      end
    end else if (t == MT_U) begin
      if (i inside {[6'd18:6'd25]}) begin
        s = SEL_NEW_REF;
      end else if (i inside {[6'd26:6'd29]}) begin
        s = SEL_SHARES;
      end else if (i inside {[6'd30:6'd33]}) begin
        s = SEL_PRICE;
      end
    end
    route = s;
  endfunction

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  assign order_type = (current_type == MT_A) || (current_type == MT_F) ||
                      (current_type == MT_E) || (current_type == MT_C) ||
                      (current_type == MT_X) || (current_type == MT_D) ||
                      (current_type == MT_U);

  // Classify the incoming byte.
  always_comb begin
    cmd.data  = in_data;
    cmd.start = (bytes_left == 6'd0);
    cmd.sel   = SEL_NONE;
    cmd.emit  = 1'b0;
    if (bytes_left != 6'd0) begin
      cmd.sel  = order_type ? route(current_type, body_index) : SEL_NONE;
      cmd.emit = order_type && (bytes_left == 6'd1);
    end
  end

  // Message framing counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left   <= 6'd0;
      body_index   <= 6'd0;
      current_type <= 8'd0;
    end else if (accept) begin
      if (bytes_left == 6'd0) begin
        current_type <= in_data;
        bytes_left   <= body_length(in_data);
        body_index   <= 6'd0;
      end else begin
        bytes_left <= bytes_left - 6'd1;
        body_index <= body_index + 6'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/mfoe_queue.sv @@
`default_nettype none

module mfoe_queue #(
  parameter int DEPTH = mfoe_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push_valid,
  output logic                      push_ready,
  input  wire mfoe_pkg::mfoe_cmd_t  push_cmd,
  output logic                      pop_valid,
  input  wire logic                 pop_ready,
  output mfoe_pkg::mfoe_cmd_t       pop_cmd
);
  import mfoe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  mfoe_cmd_t     slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue occupancy above depth");
  a_fill: assert property (@(posedge clk) disable iff (rst)
      push && !pop |=> count == $past(count) + CW'(1))
    else $error("queue count missed a push");
  a_drain: assert property (@(posedge clk) disable iff (rst)
      pop && !push |=> count == $past(count) - CW'(1))
    else $error("queue count missed a pop");
  a_ptr_sync: assert property (@(posedge clk) disable iff (rst)
      count == '0 |-> wr_ptr == rd_ptr)
    else $error("queue pointers differ while empty");

endmodule

`default_nettype wire

@@ src/mfoe_back.sv @@
`default_nettype none

module mfoe_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire mfoe_pkg::mfoe_cmd_t  cmd,
  output logic                      rec_valid,
  input  wire logic                 rec_ready,
  output mfoe_pkg::mfoe_rec_t       rec
);
  import mfoe_pkg::*;

  logic [7:0]  current_type;
  logic [15:0] locate_acc;
  logic [47:0] time_acc;
  logic [31:0] ref_acc;
  logic [31:0] new_ref_acc;
  logic [31:0] shares_acc;
  logic [31:0] price_acc;
  logic        side_flag;
  logic [31:0] record_counter;

  logic [15:0] locate_next;
  logic [47:0] time_next;
  logic [31:0] ref_next;
  logic [31:0] new_ref_next;
  logic [31:0] shares_next;
  logic [31:0] price_next;
  logic        side_next;
  logic        take;

  // A command that emits waits until the output register is free.
  assign cmd_ready = !cmd.emit || !rec_valid || rec_ready;
  assign take      = cmd_valid && cmd_ready;

  // Accumulator update for the current command.
  always_comb begin
    locate_next  = locate_acc;
    time_next    = time_acc;
    ref_next     = ref_acc;
    new_ref_next = new_ref_acc;
    shares_next  = shares_acc;
    price_next   = price_acc;
    side_next    = side_flag;
    if (cmd.start) begin
      locate_next  = '0;
      time_next    = '0;
      ref_next     = '0;
      new_ref_next = '0;
      shares_next  = '0;
      price_next   = '0;
      side_next    = 1'b0;
    end else begin
      case (cmd.sel)
        SEL_LOCATE:  locate_next  = {locate_acc[7:0], cmd.data};
        SEL_TIME:    time_next    = {time_acc[39:0], cmd.data};
        SEL_REF:     ref_next     = {ref_acc[23:0], cmd.data};
        SEL_NEW_REF: new_ref_next = {new_ref_acc[23:0], cmd.data};
        SEL_SHARES:  shares_next  = {shares_acc[23:0], cmd.data};
        SEL_PRICE:   price_next   = {price_acc[23:0], cmd.data};
        SEL_SIDE:    side_next    = (cmd.data == SIDE_BUY);
        default:     ;
      endcase
    end
  end

  // Field accumulators.
  always_ff @(posedge clk) begin
    if (take) begin
      if (cmd.start) begin
        current_type <= cmd.data;
      end
      locate_acc  <= locate_next;
      time_acc    <= time_next;
      ref_acc     <= ref_next;
      new_ref_acc <= new_ref_next;
      shares_acc  <= shares_next;
      price_acc   <= price_next;
      side_flag   <= side_next;
    end
  end

  // Record counter and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      record_counter <= '0;
      rec_valid      <= 1'b0;
    end else begin
      if (rec_valid && rec_ready) begin
        rec_valid <= 1'b0;
      end
      if (take && cmd.emit) begin
        record_counter <= record_counter + 32'd1;
        rec_valid      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.emit) begin
      rec.message_type  <= current_type;
      rec.stock_locate  <= locate_next;
      rec.timestamp     <= time_next;
      rec.order_ref     <= ref_next;
      rec.new_order_ref <= new_ref_next;
      rec.shares        <= shares_next;
      rec.price         <= price_next;
      rec.is_buy        <= side_next;
      rec.order_count   <= record_counter + 32'd1;
    end
  end

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
      take && cmd.emit |=> rec_valid && rec.order_count == record_counter)
    else $error("emitted record not presented");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
      rec_valid && !rec_ready |-> !(take && cmd.emit))
    else $error("pending record overwritten");
  a_emit_not_start: assert property (@(posedge clk) disable iff (rst)
      cmd_valid && cmd.emit |-> !cmd.start)
    else $error("type byte marked as record end");

endmodule

`default_nettype wire

@@ src/market_feed_order_extract_top.sv @@
`default_nettype none

// Channel   Dir  Width     Contents
// s_axis    in   8         tdata: data_byte
// m_axis    out  232 + 8   tdata: stock_locate, timestamp, order_ref, new_order_ref,
//                          shares, price, is_buy, order_count, zero pad;
//                          tuser: message_type
//
// One byte is accepted per cycle while the queue has room; the front framer
// classifies each byte combinationally. A record appears in the cycle after its
// last body byte leaves the command queue. Synchronous active-high reset returns
// the framer to awaiting a type byte and clears the record count and the queue.
// When the output stalls, the queue absorbs up to QUEUE_DEPTH bytes before
// s_axis_tready drops; non-record bytes keep draining around a held record.
module market_feed_order_extract_top #(
  parameter int QUEUE_DEPTH = mfoe_pkg::QUEUE_DEPTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [7:0]                           s_axis_tdata,  // [7:0] data_byte
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [15:0] stock_locate, [63:16] timestamp, [95:64] order_ref,
  // [127:96] new_order_ref, [159:128] shares, [191:160] price,
  // [192] is_buy, [224:193] order_count, rest zero
  output logic [mfoe_pkg::TDATA_BITS-1:0]           m_axis_tdata,
  output logic [7:0]                                m_axis_tuser   // [7:0] message_type
);
  import mfoe_pkg::*;

  mfoe_cmd_t front_cmd;
  mfoe_cmd_t back_cmd;
  mfoe_rec_t rec;
  logic      front_valid;
  logic      front_ready;
  logic      back_valid;
  logic      back_ready;

  mfoe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  mfoe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  mfoe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .rec_valid (m_axis_tvalid),
    .rec_ready (m_axis_tready),
    .rec       (rec)
  );

  // The type byte goes out on tuser; the other fields go out lowest first,
  // padded with zeros to whole bytes.
  assign m_axis_tuser = rec.message_type;
  assign m_axis_tdata = {{(TDATA_BITS - REC_BITS + TYPE_BITS){1'b0}},
                         rec[REC_BITS-1:TYPE_BITS]};

endmodule

`default_nettype wire
